>>> rtl/core/dotb_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and register indexes for the oscillator trim buttons block.
// No dependencies; used by dotb_debounce and debounced_oscillator_trim_buttons.
package dotb_pkg;

    // Width of the oscillator trim state and of the millisecond time base.
    localparam int TRIM_WIDTH = 8;
    localparam int TIME_WIDTH = 32;

    // Widths of the payload fields and configuration registers.
    localparam int TRIM_OUT_W   = 8;
    localparam int HOLD_W       = 8;
    localparam int FLASH_W      = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;

    // Packing: input flags, then time stamp; output trim, then flags; byte padded.
    localparam int S_FIELDS_W = 3 + TIME_WIDTH;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = TRIM_OUT_W + 3;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Reset values of the configuration registers.
    localparam logic [HOLD_W-1:0]  HOLD_RESET       = HOLD_W'(25);
    localparam logic [FLASH_W-1:0] SHORT_RESET      = FLASH_W'(50);
    localparam logic [FLASH_W-1:0] LONG_RESET       = FLASH_W'(150);
    localparam logic [7:0]         INIT_TRIM_RESET  = 8'd128;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HOLD_TIME   = 2'd0,
        REG_SHORT_FLASH = 2'd1,
        REG_LONG_FLASH  = 2'd2,
        REG_INIT_TRIM   = 2'd3
    } t_cfg_reg;

    // Debouncer phases: released and armed, timing a press, waiting for release.
    typedef enum logic [2:0] {
        PH_ARMED  = 3'b001,
        PH_TIMING = 3'b010,
        PH_LOCKED = 3'b100
    } t_phase;

endpackage

>>> rtl/core/dotb_debounce.sv
`timescale 1ns / 1ps
// One push-button debouncer with a hold time, advanced once per accepted sample.
// Depends on dotb_pkg for widths and the phase encoding.
module dotb_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_pressed,
    input  logic [dotb_pkg::TIME_WIDTH-1:0] i_now,
    input  logic [dotb_pkg::HOLD_W-1:0]     i_hold,
    output logic                          o_fire
);

    dotb_pkg::t_phase                r_phase, n_phase;
    logic [dotb_pkg::TIME_WIDTH-1:0] r_start, n_start;
    logic [dotb_pkg::TIME_WIDTH-1:0] elapsed;

    assign elapsed = i_now - r_start;

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        o_fire  = 1'b0;
        if (i_step) begin
            if (!i_pressed) begin
                n_phase = dotb_pkg::PH_ARMED;
            end else begin
                unique case (r_phase)
                    dotb_pkg::PH_ARMED: begin
                        n_phase = dotb_pkg::PH_TIMING;
                        n_start = i_now;
                    end
                    dotb_pkg::PH_TIMING: begin
                        if (elapsed >= dotb_pkg::TIME_WIDTH'(i_hold)) begin
                            n_phase = dotb_pkg::PH_LOCKED;
                            o_fire  = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = dotb_pkg::PH_LOCKED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dotb_pkg::PH_LOCKED;
        end else begin
            r_phase <= n_phase;
        end
    end

    // The press start is only read after it has been loaded.
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

endmodule

>>> rtl/core/debounced_oscillator_trim_buttons.sv
`timescale 1ns / 1ps
// Top level of the oscillator trim buttons block: three debouncers, trim and indicators.
// Depends on dotb_pkg and dotb_debounce.

// Each input transfer is one service sample of the up, down and save buttons with the
// current millisecond time; each produces exactly one output transfer with the trim
// after the sample, the two indicator levels and a save strobe. A sample is processed
// in the cycle it is accepted and its result lands in an output register, so the block
// takes one sample per clock; the only limit is the single output register, which lets
// a new sample in whenever it is empty or being drained in the same cycle. A button
// must stay pressed for hold_time_ms before its action fires, and must be released
// before it can fire again; after reset all three buttons wait for a release. Up and
// down step the trim with wrap, and save strobes out the trim including any step made
// in the same sample. Writing initial_trim also reloads the trim at once. Configuration
// must only be written while no sample is in flight.
module debounced_oscillator_trim_buttons (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave stream, tdata from bit 0: up_pressed, down_pressed, save_pressed, now_ms.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dotb_pkg::S_TDATA_W-1:0]     s_tdata,
    // Master stream, tdata from bit 0: trim_value, indicator_one, indicator_two,
    // save_strobe.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dotb_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [dotb_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [dotb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int TW = dotb_pkg::TIME_WIDTH;

    // Configuration registers.
    logic [dotb_pkg::HOLD_W-1:0]     r_hold;
    logic [dotb_pkg::FLASH_W-1:0]    r_short;
    logic [dotb_pkg::FLASH_W-1:0]    r_long;

    // Block state.
    logic [dotb_pkg::TRIM_WIDTH-1:0] r_trim, n_trim;
    logic [TW-1:0]                   r_dl_one, n_dl_one;
    logic [TW-1:0]                   r_dl_two, n_dl_two;

    // Output register.
    logic                            r_out_valid;
    logic [dotb_pkg::M_TDATA_W-1:0]  r_out_data, n_out_data;

    logic                            accept;
    logic                            up_in, down_in, save_in;
    logic [TW-1:0]                   now;
    logic                            up_fire, down_fire, save_fire;
    logic [TW-1:0]                   short_dl, long_dl;
    logic [TW-1:0]                   diff_one, diff_two;
    logic                            lit_one, lit_two;
    logic                            trim_load;
    dotb_pkg::t_cfg_reg              cfg_reg;

    assign cfg_reg   = dotb_pkg::t_cfg_reg'(i_cfg_addr);
    assign trim_load = i_cfg_we && (cfg_reg == dotb_pkg::REG_INIT_TRIM);

    // The input side is open when the result register is empty or drains this cycle.
    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign up_in   = s_tdata[0];
    assign down_in = s_tdata[1];
    assign save_in = s_tdata[2];
    assign now     = s_tdata[3 +: TW];

    dotb_debounce u_db_up (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_pressed (up_in),
        .i_now     (now),
        .i_hold    (r_hold),
        .o_fire    (up_fire)
    );

    dotb_debounce u_db_down (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_pressed (down_in),
        .i_now     (now),
        .i_hold    (r_hold),
        .o_fire    (down_fire)
    );

    dotb_debounce u_db_save (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_pressed (save_in),
        .i_now     (now),
        .i_hold    (r_hold),
        .o_fire    (save_fire)
    );

    assign short_dl = now + TW'(r_short);
    assign long_dl  = now + TW'(r_long);

    // Buttons act in the order up, down, save; save overrides both deadlines.
    always_comb begin
        n_trim   = r_trim;
        n_dl_one = r_dl_one;
        n_dl_two = r_dl_two;
        if (up_fire) begin
            n_trim   = n_trim + dotb_pkg::TRIM_WIDTH'(1);
            n_dl_one = short_dl;
        end
        if (down_fire) begin
            n_trim   = n_trim - dotb_pkg::TRIM_WIDTH'(1);
            n_dl_two = short_dl;
        end
        if (save_fire) begin
            n_dl_one = long_dl;
            n_dl_two = long_dl;
        end
    end

    // An indicator is lit while its deadline is not before now, taken modulo the
    // time base: the difference lies in the lower half of the range.
    assign diff_one = n_dl_one - now;
    assign diff_two = n_dl_two - now;
    assign lit_one  = !diff_one[TW-1];
    assign lit_two  = !diff_two[TW-1];

    always_comb begin
        n_out_data = '0;
        n_out_data[dotb_pkg::TRIM_OUT_W-1:0] = dotb_pkg::TRIM_OUT_W'(n_trim);
        n_out_data[dotb_pkg::TRIM_OUT_W]     = lit_one;
        n_out_data[dotb_pkg::TRIM_OUT_W + 1] = lit_two;
        n_out_data[dotb_pkg::TRIM_OUT_W + 2] = save_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= dotb_pkg::HOLD_RESET;
            r_short     <= dotb_pkg::SHORT_RESET;
            r_long      <= dotb_pkg::LONG_RESET;
            r_trim      <= dotb_pkg::TRIM_WIDTH'(dotb_pkg::INIT_TRIM_RESET);
            r_dl_one    <= '0;
            r_dl_two    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Only the low byte of an initial trim write is the register; it reloads
            // the trim at once.
            if (trim_load) begin
                r_trim <= dotb_pkg::TRIM_WIDTH'(i_cfg_wdata[7:0]);
            end else if (accept) begin
                r_trim <= n_trim;
            end
            if (accept) begin
                r_dl_one <= n_dl_one;
                r_dl_two <= n_dl_two;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (cfg_reg)
                    dotb_pkg::REG_HOLD_TIME:   r_hold  <= i_cfg_wdata[dotb_pkg::HOLD_W-1:0];
                    dotb_pkg::REG_SHORT_FLASH: r_short <= i_cfg_wdata;
                    dotb_pkg::REG_LONG_FLASH:  r_long  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload is captured on every accepted sample and needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // A strobed save always leaves both indicators lit in the same result.
    a_save_lights_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[dotb_pkg::TRIM_OUT_W + 2])
        |-> (r_out_data[dotb_pkg::TRIM_OUT_W] && r_out_data[dotb_pkg::TRIM_OUT_W + 1]))
        else $error("save result without both indicators lit");

    // Every accepted sample produces a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted sample produced no result");

    // Trim only moves on an accepted sample or a configuration write.
    a_trim_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && !i_cfg_we) |=> $stable(r_trim))
        else $error("trim changed without a sample or write");

    // Without a configuration write, the reported trim tracks the stored trim.
    a_trim_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_we)
        |=> (r_out_data[dotb_pkg::TRIM_OUT_W-1:0] == dotb_pkg::TRIM_OUT_W'(r_trim)))
        else $error("reported trim differs from stored trim");
`endif

endmodule
